[sv/kec_pkg.sv]
// ----------------------------------------------------------------------------
// kec_pkg
// Types and codes shared by the keyed entry cache modules.
// ----------------------------------------------------------------------------
`default_nettype none
package kec_pkg;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ADD      = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_LOOKUP   = 3'd3;
    localparam logic [2:0] CMD_PROBE    = 3'd4;
    localparam logic [2:0] CMD_REM_SLOT = 3'd5;
    localparam logic [2:0] CMD_EVICT    = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_ENTRIES_IN_USE = 2'd0;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  entry_id;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [7:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [63:0] found_key_lo;
        logic [63:0] found_key_hi;
    } rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_READ,
        BK_ACT,
        BK_OUT
    } bk_state_t;

endpackage
`default_nettype wire

[sv/keyed_entry_cache_with_lru_evict.sv]
// ----------------------------------------------------------------------------
// keyed_entry_cache_with_lru_evict
// Fully associative 16-slot key cache with least-recently-used eviction.
// Each request passes through the states SCAN, READ, ACT and OUT in turn. The slot
// scan visits one slot per cycle over entries_in_use slots, capped at 16; lookups and
// probes that hit the last-hit register skip the scan. One request at a time: the
// back end takes the next request only after the response has been taken.
// Reset clears every slot id and stamp, the time counter and the last-hit register.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_entry_cache_with_lru_evict #(
    parameter int ENTRIES = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [1:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire kec_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output kec_pkg::rsp_t      m_data
);

    logic [4:0]    eiu_reg;
    logic          q_valid, q_ready;
    kec_pkg::req_t q_req;

    assign pready = 1'b1;
    assign prdata = (paddr == kec_pkg::REG_ENTRIES_IN_USE) ? {27'd0, eiu_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) eiu_reg <= 5'd16;
        else if (psel && penable && pwrite && paddr == kec_pkg::REG_ENTRIES_IN_USE)
            eiu_reg <= pwdata[4:0];
    end

    kec_front u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_req(s_data),
        .q_valid, .q_ready, .q_req
    );

    kec_back #(.ENTRIES(ENTRIES)) u_back (
        .aclk, .aresetn, .entries_in_use(eiu_reg),
        .q_valid, .q_ready, .q_req,
        .out_valid(m_valid), .out_ready(m_ready), .out_rsp(m_data)
    );

    a_hit_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.found_key_lo == 64'd0)
        else $error("key returned without hit");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("bad status");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

[sv/kec_front.sv]
// ----------------------------------------------------------------------------
// kec_front
// Accepts requests into a two-entry queue that feeds the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module kec_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire kec_pkg::req_t in_req,
    output logic               q_valid,
    input  wire logic          q_ready,
    output kec_pkg::req_t      q_req
);

    kec_pkg::req_t buf_reg [2];
    logic          wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) buf_reg[wp_reg] <= in_req;
    end

endmodule
`default_nettype wire

[sv/kec_back.sv]
// ----------------------------------------------------------------------------
// kec_back
// Scans the slot table one slot per cycle and carries out each request.
// ----------------------------------------------------------------------------
`default_nettype none
module kec_back #(
    parameter int ENTRIES = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [4:0]    entries_in_use,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire kec_pkg::req_t q_req,
    output logic               out_valid,
    input  wire logic          out_ready,
    output kec_pkg::rsp_t      out_rsp
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int NW = (CW > 5) ? CW : 5;

    logic [7:0]   ids_reg [ENTRIES];
    logic [31:0]  stamps_reg [ENTRIES];
    logic [127:0] keys_mem [ENTRIES];
    logic [127:0] key_rd_reg;

    kec_pkg::bk_state_t state_reg, state_next;
    kec_pkg::req_t req_reg;
    kec_pkg::rsp_t rsp_reg, rsp_next;
    logic [31:0]   time_reg;
    logic          lh_valid_reg;
    logic [7:0]    lh_id_reg;
    logic [SW-1:0] lh_slot_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_reg;
    logic          free_f_reg, match_f_reg, pres_reg;
    logic [SW-1:0] free_s_reg, match_s_reg, best_s_reg;
    logic [31:0]   best_t_reg;
    logic [SW-1:0] tgt_reg;
    logic          sc_reg;

    logic [NW-1:0] n_cap;
    logic          need_scan, at_end, shortcut;
    logic [SW-1:0] cur;
    logic          idz;

    always_comb begin
        n_cap = (NW'(entries_in_use) > NW'(ENTRIES)) ? NW'(ENTRIES) : NW'(entries_in_use);
        idz   = (q_req.entry_id == 8'd0);
        shortcut = lh_valid_reg && (lh_id_reg == q_req.entry_id) && !idz;
        cur   = idx_reg[SW-1:0];
        at_end = (idx_reg + CW'(1) >= n_reg);
    end

    always_comb begin
        rsp_next = '0;
        case (req_reg.command)
            kec_pkg::CMD_ADD:
                if (req_reg.entry_id != 8'd0 && !free_f_reg) rsp_next.status = kec_pkg::ST_FULL;
            kec_pkg::CMD_REM_SLOT:
                if ({1'b0, req_reg.slot_index} >= 9'(n_reg)) rsp_next.status = kec_pkg::ST_RANGE;
            kec_pkg::CMD_EVICT:
                if (n_reg == '0) rsp_next.status = kec_pkg::ST_RANGE;
            kec_pkg::CMD_LOOKUP: if (match_f_reg) begin
                rsp_next.hit          = 1'b1;
                rsp_next.found_key_lo = key_rd_reg[63:0];
                rsp_next.found_key_hi = key_rd_reg[127:64];
            end
            kec_pkg::CMD_PROBE: rsp_next.hit = match_f_reg;
            default: ;
        endcase
    end

    assign q_ready   = (state_reg == kec_pkg::BK_IDLE);
    assign out_valid = (state_reg == kec_pkg::BK_OUT);
    assign out_rsp   = rsp_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kec_pkg::BK_IDLE: if (q_valid) state_next = kec_pkg::BK_SCAN;
            kec_pkg::BK_SCAN: if (n_reg == '0 || at_end || sc_reg)
                state_next = kec_pkg::BK_READ;
            kec_pkg::BK_READ: state_next = kec_pkg::BK_ACT;
            kec_pkg::BK_ACT:  state_next = kec_pkg::BK_OUT;
            kec_pkg::BK_OUT:  if (out_ready) state_next = kec_pkg::BK_IDLE;
            default:          state_next = kec_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kec_pkg::BK_IDLE;
            time_reg     <= '0;
            lh_valid_reg <= 1'b0;
            lh_id_reg    <= '0;
            lh_slot_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                ids_reg[i]    <= '0;
                stamps_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                kec_pkg::BK_IDLE: if (q_valid) begin
                    req_reg     <= q_req;
                    n_reg       <= n_cap[CW-1:0];
                    idx_reg     <= '0;
                    free_f_reg  <= 1'b0;
                    match_f_reg <= 1'b0;
                    pres_reg    <= 1'b0;
                    best_s_reg  <= '0;
                    best_t_reg  <= stamps_reg[0];
                    sc_reg      <= shortcut && (q_req.command == kec_pkg::CMD_LOOKUP ||
                                   q_req.command == kec_pkg::CMD_PROBE);
                    match_s_reg <= lh_slot_reg;
                end
                kec_pkg::BK_SCAN: if (n_reg != '0 && !sc_reg) begin
                    idx_reg <= idx_reg + CW'(1);
                    if (ids_reg[cur] == 8'd0 && !free_f_reg) begin
                        free_f_reg <= 1'b1;
                        free_s_reg <= cur;
                    end
                    if (ids_reg[cur] == req_reg.entry_id && req_reg.entry_id != 8'd0) begin
                        pres_reg <= 1'b1;
                        if (!match_f_reg) begin
                            match_f_reg <= 1'b1;
                            match_s_reg <= cur;
                        end
                    end
                    if (stamps_reg[cur] < best_t_reg) begin
                        best_t_reg <= stamps_reg[cur];
                        best_s_reg <= cur;
                    end
                end
                kec_pkg::BK_READ: begin
                    if (sc_reg) match_f_reg <= 1'b1;
                    case (req_reg.command)
                        kec_pkg::CMD_REM_SLOT: tgt_reg <= req_reg.slot_index[SW-1:0];
                        kec_pkg::CMD_EVICT:    tgt_reg <= best_s_reg;
                        default:               tgt_reg <= match_s_reg;
                    endcase
                    key_rd_reg <= keys_mem[match_s_reg];
                end
                kec_pkg::BK_ACT: begin
                    rsp_reg <= rsp_next;
                    case (req_reg.command)
                        kec_pkg::CMD_TICK: time_reg <= time_reg + 32'd1;
                        kec_pkg::CMD_ADD:
                            if (req_reg.entry_id != 8'd0 && free_f_reg && !pres_reg) begin
                                ids_reg[free_s_reg]    <= req_reg.entry_id;
                                stamps_reg[free_s_reg] <= time_reg;
                                keys_mem[free_s_reg]   <= {req_reg.key_hi, req_reg.key_lo};
                                if (!lh_valid_reg) begin
                                    lh_valid_reg <= 1'b1;
                                    lh_id_reg    <= req_reg.entry_id;
                                    lh_slot_reg  <= free_s_reg;
                                end
                            end
                        kec_pkg::CMD_REMOVE, kec_pkg::CMD_REM_SLOT, kec_pkg::CMD_EVICT: begin
                            if (rsp_next.status != kec_pkg::ST_RANGE &&
                                (req_reg.command != kec_pkg::CMD_REMOVE || match_f_reg)) begin
                                ids_reg[tgt_reg]    <= '0;
                                stamps_reg[tgt_reg] <= '0;
                                keys_mem[tgt_reg]   <= '0;
                                if (lh_valid_reg && ids_reg[tgt_reg] == lh_id_reg)
                                    lh_valid_reg <= 1'b0;
                            end
                        end
                        kec_pkg::CMD_LOOKUP: if (match_f_reg) begin
                            stamps_reg[tgt_reg]  <= time_reg;
                            if (!sc_reg) begin
                                lh_valid_reg <= 1'b1;
                                lh_id_reg    <= req_reg.entry_id;
                                lh_slot_reg  <= tgt_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                kec_pkg::BK_OUT: ;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire
